FILE: design/ptq_pkg.sv
// Shared constants, codes, word types and control structs of the two-class priority queue.
`timescale 1ns / 1ps
`default_nettype none
package ptq_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int MEM_DEPTH   = 2 * CAPACITY;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int KEY_FIELD_W = 32;
    localparam int REM_W       = 7;
    localparam int BATCH_W     = 4;
    localparam int MAX_BATCH   = 8;

    localparam logic [BATCH_W-1:0] BATCH_RESET = 4'd4;

    localparam logic [1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [1:0] KIND_SERVE   = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_SERVED    = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]             kind;
        logic [KEY_FIELD_W-1:0] entry_key;
        logic                   express;
    } t_in_word;

    typedef struct packed {
        logic [2:0]             status;
        logic [KEY_FIELD_W-1:0] served_key;
        logic                   last_of_run;
        logic [REM_W-1:0]       remaining;
    } t_out_word;

    typedef struct packed {
        logic       capture;
        logic       enq;
        logic       srv_init;
        logic       rd_front;
        logic       pop;
        logic       scan_init;
        logic       scan_step;
        logic       scan_next;
        logic       shift_step;
        logic       drop;
        logic       out_load;
        logic [2:0] out_code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       full;
        logic       match;
        logic       exhausted;
        logic       sel_fast;
        logic       shift_done;
        logic       last_pop;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: design/ptq_datapath.sv
// Datapath: key memory of both class rings, ring pointers, scan pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none
module ptq_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptq_pkg::t_cmd     i_cmd,
    output ptq_pkg::t_stat         o_stat,
    input  wire ptq_pkg::t_in_word i_in_data,
    input  wire logic              i_cfg_valid,
    input  wire logic [ptq_pkg::BATCH_W-1:0] i_cfg_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ptq_pkg::t_out_word     o_out_data
);

    // Offset a ring head by a logical position, wrapping at the ring size.
    function automatic logic [ptq_pkg::IDX_W-1:0] wrap_idx(
        input logic [ptq_pkg::IDX_W-1:0] base,
        input logic [ptq_pkg::CNT_W-1:0] off
    );
        logic [ptq_pkg::CNT_W:0] s;
        s = (ptq_pkg::CNT_W + 1)'(base) + (ptq_pkg::CNT_W + 1)'(off);
        if (s >= (ptq_pkg::CNT_W + 1)'(ptq_pkg::CAPACITY)) begin
            s = s - (ptq_pkg::CNT_W + 1)'(ptq_pkg::CAPACITY);
        end
        return s[ptq_pkg::IDX_W-1:0];
    endfunction

    // Fast-track ring lives in the upper half of the memory.
    function automatic logic [ptq_pkg::MEM_AW-1:0] mem_addr(
        input logic                      fast,
        input logic [ptq_pkg::IDX_W-1:0] idx
    );
        logic [ptq_pkg::MEM_AW-1:0] a;
        a = ptq_pkg::MEM_AW'(idx);
        if (fast) begin
            a = a + ptq_pkg::MEM_AW'(ptq_pkg::CAPACITY);
        end
        return a;
    endfunction

    logic [ptq_pkg::KEY_WIDTH-1:0] r_mem [ptq_pkg::MEM_DEPTH];
    logic [ptq_pkg::KEY_WIDTH-1:0] r_rdata;

    logic [ptq_pkg::BATCH_W-1:0] r_batch;
    ptq_pkg::t_in_word           r_req;
    logic [ptq_pkg::IDX_W-1:0]   r_fhead, r_rhead;
    logic [ptq_pkg::CNT_W-1:0]   r_fcnt, r_rcnt;
    logic                        r_sel;
    logic [ptq_pkg::CNT_W-1:0]   r_idx, r_pidx;
    logic                        r_pv;
    logic [ptq_pkg::BATCH_W-1:0] r_left;
    logic                        r_out_valid;
    ptq_pkg::t_out_word          r_out;

    logic [ptq_pkg::CNT_W-1:0]   w_occ;
    logic [ptq_pkg::IDX_W-1:0]   w_shead;
    logic [ptq_pkg::CNT_W-1:0]   w_scnt;
    logic                        w_front_fast;
    logic                        w_more;
    logic                        w_rd_en;
    logic [ptq_pkg::MEM_AW-1:0]  w_rd_addr;
    logic                        w_wr_en;
    logic [ptq_pkg::MEM_AW-1:0]  w_wr_addr;
    logic [ptq_pkg::KEY_WIDTH-1:0] w_wr_data;
    logic [ptq_pkg::KEY_WIDTH-1:0] w_key;
    logic [ptq_pkg::BATCH_W-1:0] w_nbatch;
    logic [ptq_pkg::BATCH_W-1:0] w_ntake;
    logic                        w_out_free;
    logic [ptq_pkg::CNT_W-1:0]   w_rem;

    assign w_occ        = r_fcnt + r_rcnt;
    assign w_shead      = r_sel ? r_fhead : r_rhead;
    assign w_scnt       = r_sel ? r_fcnt : r_rcnt;
    assign w_front_fast = (r_fcnt != '0);
    assign w_more       = (r_idx < w_scnt);
    assign w_key        = ptq_pkg::KEY_WIDTH'(r_req.entry_key);
    assign w_out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        w_rd_en   = i_cmd.rd_front || ((i_cmd.scan_step || i_cmd.shift_step) && w_more);
        w_rd_addr = i_cmd.rd_front
                  ? mem_addr(w_front_fast, w_front_fast ? r_fhead : r_rhead)
                  : mem_addr(r_sel, wrap_idx(w_shead, r_idx));
        if (i_cmd.enq) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_req.express ? mem_addr(1'b1, wrap_idx(r_fhead, r_fcnt))
                                      : mem_addr(1'b0, wrap_idx(r_rhead, r_rcnt));
            w_wr_data = w_key;
        end else begin
            // Closing the gap: the word read for position p moves down to p - 1.
            w_wr_en   = i_cmd.shift_step && r_pv;
            w_wr_addr = mem_addr(r_sel, wrap_idx(w_shead, r_pidx - ptq_pkg::CNT_W'(1)));
            w_wr_data = r_rdata;
        end
    end

    always_comb begin
        if (r_batch == '0) begin
            w_nbatch = ptq_pkg::BATCH_W'(1);
        end else if (r_batch > ptq_pkg::BATCH_W'(ptq_pkg::MAX_BATCH)) begin
            w_nbatch = ptq_pkg::BATCH_W'(ptq_pkg::MAX_BATCH);
        end else begin
            w_nbatch = r_batch;
        end
        if (ptq_pkg::CNT_W'(w_nbatch) > w_occ) begin
            w_ntake = ptq_pkg::BATCH_W'(w_occ);
        end else begin
            w_ntake = w_nbatch;
        end
    end

    always_comb begin
        case (i_cmd.out_code)
            ptq_pkg::ST_ACCEPTED: w_rem = w_occ + ptq_pkg::CNT_W'(1);
            ptq_pkg::ST_SERVED:   w_rem = w_occ - ptq_pkg::CNT_W'(1);
            default:              w_rem = w_occ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        if (i_cmd.scan_step || i_cmd.shift_step) begin
            r_pidx <= r_idx;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= i_cmd.out_code;
            r_out.served_key  <= (i_cmd.out_code == ptq_pkg::ST_SERVED)
                               ? ptq_pkg::KEY_FIELD_W'(r_rdata) : '0;
            r_out.last_of_run <= (i_cmd.out_code == ptq_pkg::ST_SERVED)
                               ? (r_left == ptq_pkg::BATCH_W'(1)) : 1'b1;
            r_out.remaining   <= ptq_pkg::REM_W'(w_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch     <= ptq_pkg::BATCH_RESET;
            r_fhead     <= '0;
            r_rhead     <= '0;
            r_fcnt      <= '0;
            r_rcnt      <= '0;
            r_sel       <= 1'b1;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_batch <= i_cfg_data;
            end
            if (i_cmd.enq) begin
                if (r_req.express) begin
                    r_fcnt <= r_fcnt + ptq_pkg::CNT_W'(1);
                end else begin
                    r_rcnt <= r_rcnt + ptq_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.srv_init) begin
                r_left <= w_ntake;
            end
            if (i_cmd.pop) begin
                r_left <= r_left - ptq_pkg::BATCH_W'(1);
                if (w_front_fast) begin
                    r_fhead <= wrap_idx(r_fhead, ptq_pkg::CNT_W'(1));
                    r_fcnt  <= r_fcnt - ptq_pkg::CNT_W'(1);
                end else begin
                    r_rhead <= wrap_idx(r_rhead, ptq_pkg::CNT_W'(1));
                    r_rcnt  <= r_rcnt - ptq_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.drop) begin
                if (r_sel) begin
                    r_fcnt <= r_fcnt - ptq_pkg::CNT_W'(1);
                end else begin
                    r_rcnt <= r_rcnt - ptq_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.scan_init || i_cmd.scan_next) begin
                r_sel <= i_cmd.scan_init;
                r_idx <= '0;
                r_pv  <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.shift_step) begin
                r_pv <= w_more;
                if (w_more) begin
                    r_idx <= r_idx + ptq_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.kind       = r_req.kind;
        o_stat.empty      = (w_occ == '0);
        o_stat.full       = (w_occ >= ptq_pkg::CNT_W'(ptq_pkg::CAPACITY));
        o_stat.match      = r_pv && (r_rdata == w_key);
        o_stat.exhausted  = !r_pv && !w_more;
        o_stat.sel_fast   = r_sel;
        o_stat.shift_done = !r_pv;
        o_stat.last_pop   = (r_left == ptq_pkg::BATCH_W'(1));
        o_stat.out_free   = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: design/ptq_ctrl.sv
// Controller state machine: sequences enqueue, serve, search and gap closing.
`timescale 1ns / 1ps
`default_nettype none
module ptq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ptq_pkg::t_stat i_stat,
    output ptq_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENQ,
        S_SRV_RD,
        S_SRV_OUT,
        S_SCAN,
        S_SHIFT,
        S_REPLY
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_code, n_code;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    ptq_pkg::KIND_ENQUEUE: begin
                        n_state = S_ENQ;
                    end
                    ptq_pkg::KIND_SERVE: begin
                        if (i_stat.empty) begin
                            n_code  = ptq_pkg::ST_EMPTY;
                            n_state = S_REPLY;
                        end else begin
                            o_cmd.srv_init = 1'b1;
                            n_state        = S_SRV_RD;
                        end
                    end
                    ptq_pkg::KIND_REMOVE: begin
                        if (i_stat.empty) begin
                            n_code  = ptq_pkg::ST_EMPTY;
                            n_state = S_REPLY;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ENQ: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.out_code = ptq_pkg::ST_FULL;
                    end else begin
                        o_cmd.enq      = 1'b1;
                        o_cmd.out_code = ptq_pkg::ST_ACCEPTED;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SRV_RD: begin
                o_cmd.rd_front = 1'b1;
                n_state        = S_SRV_OUT;
            end
            S_SRV_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_code = ptq_pkg::ST_SERVED;
                    o_cmd.pop      = 1'b1;
                    n_state        = i_stat.last_pop ? S_IDLE : S_SRV_RD;
                end
            end
            S_SCAN: begin
                // The read for the next position is issued in the same cycle as the match shows up,
                // so the gap closing starts with that word.
                if (i_stat.match) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SHIFT;
                end else if (i_stat.exhausted) begin
                    if (i_stat.sel_fast) begin
                        o_cmd.scan_next = 1'b1;
                    end else begin
                        n_code  = ptq_pkg::ST_NOT_FOUND;
                        n_state = S_REPLY;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.drop = 1'b1;
                    n_code     = ptq_pkg::ST_REMOVED;
                    n_state    = S_REPLY;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_code = r_code;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ptq_pkg::ST_ACCEPTED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

FILE: design/two_class_priority_queue.sv
// Top level of the two-class priority queue: controller, datapath and checks.
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_in_data  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready    | o_out_data (t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_data (batch size)
//
// One request is worked at a time, as the single read port of the key memory is walked one
// position a cycle through the class rings and then through the gap closing of a removal.
// Reset sets the counters, pointers, batch size and output flag only; the key memory needs no clearing pass.
// The output register lets a new word be accepted while a result still waits; a stalled
// output holds the controller in its reply state until the word is taken.
`timescale 1ns / 1ps
`default_nettype none
module two_class_priority_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire ptq_pkg::t_in_word           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output ptq_pkg::t_out_word               o_out_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ptq_pkg::BATCH_W-1:0] i_cfg_data
);

    ptq_pkg::t_cmd  cmd;
    ptq_pkg::t_stat stat;

    ptq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_cfg_ready = 1'b1;

    // A result word is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result word loaded while the previous one was still pending");

    // An entry is only written when there is room for it.
    a_enq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.enq |-> !stat.full)
        else $error("enqueue written into a full queue");

    // Only served words carry a key, and they alone may be mid-run.
    a_plain_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ptq_pkg::ST_SERVED))
        |-> (o_out_data.served_key == '0) && o_out_data.last_of_run)
        else $error("non-served result with a key or without the last mark");

    // The reported fill level never exceeds the capacity.
    a_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.remaining <= ptq_pkg::REM_W'(ptq_pkg::CAPACITY)))
        else $error("remaining count above capacity");

endmodule
`default_nettype wire

FILE: tb/ptq_reply_checker.sv
// Reply checker of the two-class priority queue: mirrors the queue and compares every reply word.
`timescale 1ns / 1ps
module ptq_reply_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire ptq_pkg::t_in_word           i_in_data,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire ptq_pkg::t_out_word          i_out_data,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [ptq_pkg::BATCH_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_replies_due,
    output int                               o_replies_seen,
    output int                               o_full_count
);
    import ptq_pkg::*;

    // Mirror of the queue: fast-track entries first, then regular ones.
    logic [KEY_FIELD_W-1:0] mirror_key  [CAPACITY];
    logic                   mirror_fast [CAPACITY];
    int                     held        = 0;
    int                     held_fast   = 0;
    logic [BATCH_W-1:0]     batch_limit = BATCH_RESET;
    t_out_word              expected_replies [$];
    int                     fails       = 0;
    int                     seen        = 0;
    int                     rejections  = 0;

    task automatic queue_reply(input logic [2:0] status, input logic [KEY_FIELD_W-1:0] key,
                               input logic last);
        t_out_word word;
        word.status      = status;
        word.served_key  = key;
        word.last_of_run = last;
        word.remaining   = REM_W'(held);
        expected_replies.push_back(word);
        if (status == ST_FULL) begin
            rejections++;
        end
    endtask

    task automatic close_gap(input int pos);
        int i;
        if (mirror_fast[pos]) begin
            held_fast--;
        end
        for (i = pos; i + 1 < held; i++) begin
            mirror_key[i]  = mirror_key[i + 1];
            mirror_fast[i] = mirror_fast[i + 1];
        end
        held--;
    endtask

    task automatic apply_request(input t_in_word req);
        int   take;
        int   pos;
        logic found;
        logic [KEY_FIELD_W-1:0] head;
        case (req.kind)
            KIND_ENQUEUE: begin
                if (held >= CAPACITY) begin
                    queue_reply(ST_FULL, '0, 1'b1);
                end else begin
                    if (req.express) begin
                        // Open a slot right behind the last fast-track entry.
                        for (pos = held; pos > held_fast; pos--) begin
                            mirror_key[pos]  = mirror_key[pos - 1];
                            mirror_fast[pos] = mirror_fast[pos - 1];
                        end
                        mirror_key[held_fast]  = req.entry_key;
                        mirror_fast[held_fast] = 1'b1;
                        held_fast++;
                    end else begin
                        mirror_key[held]  = req.entry_key;
                        mirror_fast[held] = 1'b0;
                    end
                    held++;
                    queue_reply(ST_ACCEPTED, '0, 1'b1);
                end
            end
            KIND_SERVE: begin
                if (held == 0) begin
                    queue_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    // A zero batch size still serves one entry; large ones saturate.
                    if (batch_limit == 0) begin
                        take = 1;
                    end else if (batch_limit > MAX_BATCH) begin
                        take = MAX_BATCH;
                    end else begin
                        take = batch_limit;
                    end
                    if (take > held) begin
                        take = held;
                    end
                    for (pos = 0; pos < take; pos++) begin
                        head = mirror_key[0];
                        close_gap(0);
                        queue_reply(ST_SERVED, head, pos + 1 == take);
                    end
                end
            end
            KIND_REMOVE: begin
                if (held == 0) begin
                    queue_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    found = 1'b0;
                    for (pos = 0; pos < held && !found; pos++) begin
                        if (mirror_key[pos] == req.entry_key) begin
                            close_gap(pos);
                            found = 1'b1;
                        end
                    end
                    queue_reply(found ? ST_REMOVED : ST_NOT_FOUND, '0, 1'b1);
                end
            end
            default: begin
                // The unused request code is dropped without a reply.
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [KEY_FIELD_W-1:0] want,
                               input logic [KEY_FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            held        = 0;
            held_fast   = 0;
            batch_limit = BATCH_RESET;
            expected_replies.delete();
        end else begin
            // Replies are compared before the new request is mirrored, so a reply
            // can never be matched against the request accepted on the same edge.
            if (i_out_valid && i_out_ready) begin
                seen++;
                if (expected_replies.size() == 0) begin
                    $error("reply word 0x%0h arrived with no reply expected", i_out_data);
                    fails++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, i_out_data.status);
                    check_field("served_key", want.served_key, i_out_data.served_key);
                    check_field("last_of_run", want.last_of_run, i_out_data.last_of_run);
                    check_field("remaining", want.remaining, i_out_data.remaining);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                batch_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                apply_request(i_in_data);
            end
        end
        o_fail_count   <= fails;
        o_replies_due  <= expected_replies.size();
        o_replies_seen <= seen;
        o_full_count   <= rejections;
    end

endmodule

FILE: tb/tb.sv
// Testbench top of the two-class priority queue: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
    import ptq_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         KEY_POOL      = 16;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         QUIET_LIMIT   = 4000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_in_word           in_data;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_word          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [BATCH_W-1:0] cfg_data;

    int fail_count;
    int replies_due;
    int replies_seen;
    int full_count;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int requests_sent = 0;
    int batch_writes  = 0;
    int quiet_cycles  = 0;

    logic [KEY_FIELD_W-1:0] key_pool [KEY_POOL];

    two_class_priority_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ptq_reply_checker reply_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_replies_due  (replies_due),
        .o_replies_seen (replies_seen),
        .o_full_count   (full_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("No word moved on any channel for %0d cycles.", QUIET_LIMIT);
            $display("two_class_priority_queue: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input t_in_word req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [KEY_FIELD_W-1:0] key,
                               input logic fast);
        t_in_word req;
        req.kind      = kind;
        req.entry_key = key;
        req.express   = fast;
        send_request(req);
    endtask

    // Holds the sender back until every reply of the requests already taken is in.
    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_batch(input logic [BATCH_W-1:0] size);
        drain_replies();
        // A dropped request may still be in the controller with nothing expected.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        batch_writes++;
    endtask

    function automatic t_in_word make_request(input int enq_pct, input int rem_pct,
                                              input int srv_pct);
        t_in_word req;
        int       roll;
        roll = $urandom_range(99);
        // Most keys come from a small pool so that removals find matches and duplicates.
        req.entry_key = ($urandom_range(3) == 0) ? $urandom
                                                 : key_pool[$urandom_range(KEY_POOL - 1)];
        req.express   = $urandom_range(1);
        if (roll < enq_pct) begin
            req.kind = KIND_ENQUEUE;
        end else if (roll < enq_pct + rem_pct) begin
            req.kind = KIND_REMOVE;
        end else if (roll < enq_pct + rem_pct + srv_pct) begin
            req.kind = KIND_SERVE;
        end else begin
            req.kind = KIND_UNUSED;
        end
        return req;
    endfunction

    task automatic run_phase(input logic [BATCH_W-1:0] size, input int send_pct,
                             input int stall, input int count, input int enq_pct,
                             input int rem_pct, input int srv_pct);
        write_batch(size);
        send_idle_pct = send_pct;
        stall_pct     = stall;
        repeat (count) begin
            if ($urandom_range(49) == 0) begin
                drain_replies();
            end
            send_request(make_request(enq_pct, rem_pct, srv_pct));
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, the dropped request code, then both classes and key extremes.
        send_fields(KIND_SERVE,   32'h0000_0000, 1'b0);
        send_fields(KIND_REMOVE,  32'h0000_0000, 1'b1);
        send_fields(KIND_UNUSED,  32'hFFFF_FFFF, 1'b1);
        send_fields(KIND_ENQUEUE, 32'h0000_0000, 1'b0);
        send_fields(KIND_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
        send_fields(KIND_ENQUEUE, 32'hA5A5_A5A5, 1'b1);
        send_fields(KIND_ENQUEUE, 32'h5A5A_5A5A, 1'b1);
        send_fields(KIND_ENQUEUE, 32'h1234_5678, 1'b0);
        send_fields(KIND_REMOVE,  32'hDEAD_BEEF, 1'b0);
        send_fields(KIND_REMOVE,  32'hFFFF_FFFF, 1'b1);
        send_fields(KIND_REMOVE,  32'hA5A5_A5A5, 1'b0);
        // Duplicate key: the fast-track copy sits nearer the front and goes first.
        send_fields(KIND_ENQUEUE, 32'h1234_5678, 1'b1);
        send_fields(KIND_REMOVE,  32'h1234_5678, 1'b0);
        send_fields(KIND_SERVE,   32'hFFFF_FFFF, 1'b1);
        send_fields(KIND_SERVE,   32'h0000_0000, 1'b0);

        write_batch('0);
        send_fields(KIND_ENQUEUE, 32'h0000_0001, 1'b0);
        send_fields(KIND_ENQUEUE, 32'h8000_0000, 1'b1);
        send_fields(KIND_ENQUEUE, 32'h7FFF_FFFF, 1'b0);
        send_fields(KIND_SERVE,   32'h0000_0000, 1'b0);
        write_batch('1);
        send_fields(KIND_SERVE,   32'h0000_0000, 1'b1);

        run_phase(4'd8,   0,  0, 80, 60, 20, 18);
        // Enqueue-heavy with one-entry serves, so the queue reaches capacity.
        run_phase(4'd1,  47,  0, 90, 85,  8,  5);
        run_phase(4'd12,  0, 47, 70, 45, 20, 33);
        run_phase(4'd5,  30, 30, 80, 55, 25, 18);
        run_phase(4'd3,   0,  0, 70, 40, 25, 33);

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests over five traffic mixes with %0d batch-size writes.",
                 requests_sent, batch_writes);
        $display("Checked %0d reply words; %0d enqueues were turned away at capacity.",
                 replies_seen, full_count);
        if (fail_count == 0) begin
            $display("two_class_priority_queue: match");
        end else begin
            $display("two_class_priority_queue: mismatch");
        end
        $finish;
    end

endmodule
